### sv/nrt_pkg.sv
// ----------------------------------------------------------------------------
// Rule table package
// Types, codes and helper functions shared by the rule table cells and the
// top level.
// ----------------------------------------------------------------------------
package nrt_pkg;

  localparam int unsigned TableEntriesDefault = 64;

  // Request kinds.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_MATCH  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NO_LOCAL  = 3'd4;

  // Protocols and transports that bear on rule validity.
  localparam logic [2:0] PROTO_INET    = 3'd0;
  localparam logic [2:0] PROTO_INET6   = 3'd1;
  localparam logic [2:0] PROTO_UNIX    = 3'd2;
  localparam logic [2:0] PROTO_NETLINK = 3'd3;
  localparam logic [2:0] PROTO_PACKET  = 3'd4;
  localparam logic [2:0] TRANS_TCP     = 3'd0;
  localparam logic [2:0] TRANS_RAW     = 3'd3;
  localparam logic [2:0] TRANS_STREAM  = 3'd4;
  localparam logic [2:0] TRANS_DGRAM   = 3'd6;
  localparam logic [2:0] OP_CREATE     = 3'd0;
  localparam logic [2:0] OP_RECEIVE    = 3'd6;
  localparam logic [2:0] OP_INVALID    = 3'd7;
  localparam logic [1:0] FAM_IPV4      = 2'd0;
  localparam logic [1:0] FAM_IPV6      = 2'd1;
  localparam logic [1:0] FAM_NONE      = 2'd2;
  localparam logic [7:0] PREFIX_MAX    = 8'd128;

  // Endpoint metadata: family, port and prefix length.
  typedef struct packed {
    logic [1:0]  family;
    logic [15:0] port;
    logic [7:0]  pfx_bits;
  } meta_t;

  // One endpoint: metadata and 128-bit address.
  typedef struct packed {
    meta_t        meta;
    logic [63:0]  addr_hi;
    logic [63:0]  addr_lo;
  } endpoint_t;

  // Request class: operation, protocol and transport.
  typedef struct packed {
    logic [2:0] op_type;
    logic [2:0] protocol;
    logic [2:0] transport;
  } class_t;

  // Request token that walks along the row of cells.
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    class_t     cls;
    logic       lpres;
    logic       rpres;
    endpoint_t  lep;
    endpoint_t  rep;
    logic       done;
  } tok_t;

  // Protocol and transport go together.
  function automatic logic combo_ok(input logic [2:0] pr, input logic [2:0] tr);
    logic ok;
    case (pr)
      PROTO_INET, PROTO_INET6:     ok = (tr <= TRANS_RAW);
      PROTO_UNIX:                  ok = (tr >= TRANS_STREAM) && (tr <= TRANS_DGRAM);
      PROTO_NETLINK, PROTO_PACKET: ok = (tr == TRANS_RAW);
      default:                     ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic meta_ok(input meta_t m);
    return (m.family <= FAM_IPV6) && (m.pfx_bits <= PREFIX_MAX);
  endfunction

  // A stored rule endpoint agrees with a requested endpoint.
  function automatic logic endpoint_agrees(input endpoint_t r, input endpoint_t q);
    logic [127:0] mask;
    logic [127:0] diff;
    if (r.meta.pfx_bits != 8'd0) begin
      mask = ~({128{1'b1}} >> r.meta.pfx_bits);
    end else if (r.meta.family == FAM_IPV4) begin
      mask = {{32{1'b1}}, {96{1'b0}}};
    end else begin
      mask = {128{1'b1}};
    end
    diff = {r.addr_hi, r.addr_lo} ^ {q.addr_hi, q.addr_lo};
    return (r.meta.family == q.meta.family) &&
           ((r.meta.port == 16'd0) || (r.meta.port == q.meta.port)) &&
           ((diff & mask) == 128'd0);
  endfunction

endpackage

### sv/nrt_cell.sv
// ----------------------------------------------------------------------------
// Rule table cell
// Holds one rule and acts on the request token as it passes, then registers the
// token and hands it on to the next cell.
// ----------------------------------------------------------------------------
module nrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  nrt_pkg::tok_t tok_in,
  output nrt_pkg::tok_t tok_out
);
  import nrt_pkg::*;

  logic      valid;
  class_t    cls;
  endpoint_t lep;
  endpoint_t rep;

  logic hit_append;
  logic hit_remove;
  logic hit_match;

  // Decide whether this cell claims the token.
  always_comb begin
    hit_append = 1'b0;
    hit_remove = 1'b0;
    hit_match  = 1'b0;
    if (tok_in.vld && !tok_in.done) begin
      case (tok_in.kind)
        KIND_APPEND: hit_append = !valid;
        KIND_REMOVE: hit_remove = valid && (cls == tok_in.cls) &&
                                  (lep == tok_in.lep) && (rep == tok_in.rep);
        KIND_MATCH:  hit_match  = valid && (cls == tok_in.cls) &&
                                  (!tok_in.lpres || endpoint_agrees(lep, tok_in.lep)) &&
                                  (!tok_in.rpres || endpoint_agrees(rep, tok_in.rep));
        default: ;
      endcase
    end
  end

  // Valid bit and token hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      if (hit_append) begin
        valid <= 1'b1;
      end else if (hit_remove) begin
        valid <= 1'b0;
      end
      tok_out.vld <= tok_in.vld;
    end
  end

  // Rule payload and the rest of the token.
  always_ff @(posedge clk) begin
    if (hit_append) begin
      cls <= tok_in.cls;
      lep <= tok_in.lep;
      rep <= tok_in.rep;
    end
    tok_out.kind  <= tok_in.kind;
    tok_out.cls   <= tok_in.cls;
    tok_out.lpres <= tok_in.lpres;
    tok_out.rpres <= tok_in.rpres;
    tok_out.lep   <= tok_in.lep;
    tok_out.rep   <= tok_in.rep;
    tok_out.done  <= tok_in.done | hit_append | hit_remove | hit_match;
  end

endmodule

### sv/network_rule_table_cidr_match.sv
// ----------------------------------------------------------------------------
// Network rule table with CIDR endpoint match
// Appends, removes and matches access rules held in a row of cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         request beat: local endpoint, then remote endpoint
// m_axis   out        one result per remote beat: status, matched, rule total
//
// A local beat gives no result. A remote beat that reaches the table launches
// a token that walks the row of cells, one cell a cycle, and the result is
// registered when the token leaves the last cell; rejected or unpaired remote
// beats give a result on the next cycle. No beat is taken from acceptance of
// a remote beat until its result is taken.
// Reset clears all valid bits at once and the pending request.
// ----------------------------------------------------------------------------
module network_rule_table_cidr_match #(
  parameter int unsigned TABLE_ENTRIES = nrt_pkg::TableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op_type[2:0], protocol[5:3], transport[8:6], side_present[9], family[11:10],
  // port[27:12], pfx_bits[35:28], addr_hi[99:36], addr_lo[163:100]
  input  logic [167:0] s_axis_tdata,
  // kind[1:0], beat_side[2]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], matched[3], rule_total[10:4]
  output logic [15:0]  m_axis_tdata
);
  import nrt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  // Unpack the input beat.
  logic      in_side;
  logic [1:0] in_kind;
  class_t    in_cls;
  logic      in_pres;
  endpoint_t in_ep;
  assign in_kind           = s_axis_tuser[1:0];
  assign in_side           = s_axis_tuser[2];
  assign in_cls.op_type    = s_axis_tdata[2:0];
  assign in_cls.protocol   = s_axis_tdata[5:3];
  assign in_cls.transport  = s_axis_tdata[8:6];
  assign in_pres           = s_axis_tdata[9];
  assign in_ep.meta.family = s_axis_tdata[11:10];
  assign in_ep.meta.port   = s_axis_tdata[27:12];
  assign in_ep.meta.pfx_bits = s_axis_tdata[35:28];
  assign in_ep.addr_hi     = s_axis_tdata[99:36];
  assign in_ep.addr_lo     = s_axis_tdata[163:100];

  logic            busy;
  logic            pend;
  logic [1:0]      pend_kind;
  class_t          pend_cls;
  logic            pend_pres;
  endpoint_t       pend_ep;
  logic [CntW-1:0] count;
  logic            res_vld;
  logic [2:0]      res_status;
  logic            res_matched;

  tok_t tok [TABLE_ENTRIES+1];

  logic       accept;
  logic       remote;
  logic       rule_bad;
  logic       reject;
  logic [2:0] reject_status;
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign remote        = accept && in_side;
  assign rule_bad      = (pend_cls.op_type == OP_INVALID) ||
                         (pend_cls.protocol > PROTO_PACKET) ||
                         !combo_ok(pend_cls.protocol, pend_cls.transport) ||
                         !meta_ok(pend_ep.meta) || !meta_ok(in_ep.meta);

  // Remote beats that are answered at once without walking the row.
  always_comb begin
    reject        = 1'b1;
    reject_status = ST_INVALID;
    if (!pend) begin
      reject_status = ST_NO_LOCAL;
    end else if (pend_kind == KIND_APPEND && rule_bad) begin
      reject_status = ST_INVALID;
    end else if (pend_kind == KIND_APPEND && count >= CntW'(TABLE_ENTRIES)) begin
      reject_status = ST_FULL;
    end else if (pend_kind == KIND_APPEND || pend_kind == KIND_REMOVE ||
                 pend_kind == KIND_MATCH) begin
      reject        = 1'b0;
      reject_status = ST_OK;
    end
  end

  // Pending header, busy flag, immediate results and table-walk results.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend       <= 1'b0;
      count      <= '0;
      res_vld    <= 1'b0;
      tok[0].vld <= 1'b0;
    end else begin
      tok[0].vld <= remote && !reject;
      if (accept && !in_side) begin
        pend <= 1'b1;
      end else if (remote) begin
        pend <= 1'b0;
      end
      // Result transaction frees the block.
      if (remote) begin
        busy <= 1'b1;
      end else if (res_vld && m_axis_tready) begin
        busy <= 1'b0;
      end
      if (remote && reject) begin
        res_vld <= 1'b1;
      end else if (tok[TABLE_ENTRIES].vld) begin
        res_vld <= 1'b1;
      end else if (res_vld && m_axis_tready) begin
        res_vld <= 1'b0;
      end
      if (remote) begin
        res_status  <= reject_status;
        res_matched <= 1'b0;
      end else if (tok[TABLE_ENTRIES].vld) begin
        // Token leaving the last cell completes the request.
        case (tok[TABLE_ENTRIES].kind)
          KIND_APPEND: begin
            res_status  <= ST_OK;
            res_matched <= 1'b0;
            count       <= count + CntW'(1);
          end
          KIND_REMOVE: begin
            res_matched <= 1'b0;
            if (tok[TABLE_ENTRIES].done) begin
              res_status <= ST_OK;
              count      <= count - CntW'(1);
            end else begin
              res_status <= ST_NOT_FOUND;
            end
          end
          default: begin
            res_status  <= ST_OK;
            res_matched <= tok[TABLE_ENTRIES].done;
          end
        endcase
      end
    end
  end

  // Pending payload and the launch token's payload.
  always_ff @(posedge clk) begin
    if (accept && !in_side) begin
      pend_kind <= in_kind;
      pend_cls  <= in_cls;
      pend_pres <= in_pres;
      pend_ep   <= in_ep;
    end
    if (remote) begin
      tok[0].kind  <= pend_kind;
      tok[0].cls   <= pend_cls;
      tok[0].lpres <= pend_pres;
      tok[0].rpres <= in_pres;
      tok[0].lep   <= pend_ep;
      tok[0].rep   <= in_ep;
      tok[0].done  <= 1'b0;
    end
  end

  // Row of rule cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    nrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign m_axis_tvalid = res_vld;
  assign m_axis_tdata  = {5'd0, 7'(count), res_matched, res_status};

endmodule

### bench/network_rule_table_checker.sv
// ----------------------------------------------------------------------------
// Rule table result checker
// Watches both stream channels of the rule table, keeps its own copy of the
// table and the pending request, predicts the result of every remote beat
// and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module network_rule_table_checker #(
  parameter int unsigned ROWS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [15:0]  m_tdata,
  output int           fail_count,
  output int           awaiting
);

  timeunit 1ns;
  timeprecision 1ps;

  import nrt_pkg::*;

  localparam logic SIDE_LOCAL = 1'b0;

  typedef struct {
    logic [2:0] status;
    logic       matched;
    logic [6:0] total;
  } rule_reply_t;

  rule_reply_t reply_q[$];

  // Shadow of the table.
  bit        row_vld[ROWS];
  class_t    row_cls[ROWS];
  endpoint_t row_l[ROWS];
  endpoint_t row_r[ROWS];
  int        row_count;

  // Shadow of the request waiting for its remote beat.
  bit        pend_vld;
  logic [1:0] pend_kind;
  class_t    pend_cls;
  logic      pend_lpres;
  endpoint_t pend_lep;

  // Protocol and transport pairing.
  function automatic bit pairing_ok(input logic [2:0] pr, input logic [2:0] tr);
    case (pr)
      PROTO_INET, PROTO_INET6:     return tr <= TRANS_RAW;
      PROTO_UNIX:                  return tr >= TRANS_STREAM && tr <= TRANS_DGRAM;
      PROTO_NETLINK, PROTO_PACKET: return tr == TRANS_RAW;
      default:                     return 1'b0;
    endcase
  endfunction

  function automatic bit side_ok(input meta_t m);
    return m.family <= FAM_IPV6 && m.pfx_bits <= PREFIX_MAX;
  endfunction

  // Rule endpoint against a requested endpoint.
  function automatic bit ends_agree(input endpoint_t r, input endpoint_t q);
    logic [127:0] keep;
    int           p;
    p = int'(r.meta.pfx_bits);
    if (p > 128) p = 128;
    if (p != 0) begin
      keep = {128{1'b1}} << (128 - p);
    end else if (r.meta.family == FAM_IPV4) begin
      keep = {{32{1'b1}}, 96'd0};
    end else begin
      keep = {128{1'b1}};
    end
    if (r.meta.family != q.meta.family) return 1'b0;
    if (r.meta.port != 16'd0 && r.meta.port != q.meta.port) return 1'b0;
    return ((({r.addr_hi, r.addr_lo} ^ {q.addr_hi, q.addr_lo}) & keep) == 128'd0);
  endfunction

  // Apply one accepted request beat to the shadow state.
  task automatic predict_beat(input logic [2:0] user, input logic [167:0] d);
    class_t      c;
    endpoint_t   ep;
    logic        pres;
    rule_reply_t rep;
    int          i;
    c.op_type      = d[2:0];
    c.protocol     = d[5:3];
    c.transport    = d[8:6];
    pres           = d[9];
    ep.meta.family = d[11:10];
    ep.meta.port   = d[27:12];
    ep.meta.pfx_bits = d[35:28];
    ep.addr_hi     = d[99:36];
    ep.addr_lo     = d[163:100];
    if (user[2] == SIDE_LOCAL) begin
      pend_vld   = 1'b1;
      pend_kind  = user[1:0];
      pend_cls   = c;
      pend_lpres = pres;
      pend_lep   = ep;
      return;
    end
    rep.status  = ST_OK;
    rep.matched = 1'b0;
    if (!pend_vld) begin
      rep.status = ST_NO_LOCAL;
    end else begin
      pend_vld = 1'b0;
      case (pend_kind)
        KIND_APPEND: begin
          if (pend_cls.op_type == OP_INVALID || pend_cls.protocol > PROTO_PACKET ||
              pend_cls.transport > TRANS_DGRAM ||
              !pairing_ok(pend_cls.protocol, pend_cls.transport) ||
              !side_ok(pend_lep.meta) || !side_ok(ep.meta)) begin
            rep.status = ST_INVALID;
          end else if (row_count >= ROWS) begin
            rep.status = ST_FULL;
          end else begin
            // Lowest free row takes the rule.
            for (i = 0; i < ROWS; i++) begin
              if (!row_vld[i]) break;
            end
            row_vld[i] = 1'b1;
            row_cls[i] = pend_cls;
            row_l[i]   = pend_lep;
            row_r[i]   = ep;
            row_count++;
          end
        end
        KIND_REMOVE: begin
          rep.status = ST_NOT_FOUND;
          for (i = 0; i < ROWS; i++) begin
            if (row_vld[i] && row_cls[i] == pend_cls && row_l[i] == pend_lep &&
                row_r[i] == ep) begin
              row_vld[i] = 1'b0;
              row_count--;
              rep.status = ST_OK;
              break;
            end
          end
        end
        KIND_MATCH: begin
          for (i = 0; i < ROWS; i++) begin
            if (row_vld[i] && row_cls[i] == pend_cls &&
                (!pend_lpres || ends_agree(row_l[i], pend_lep)) &&
                (!pres || ends_agree(row_r[i], ep))) begin
              rep.matched = 1'b1;
              break;
            end
          end
        end
        default: rep.status = ST_INVALID;
      endcase
    end
    rep.total = row_count[6:0];
    reply_q.push_back(rep);
  endtask

  // Compare results, then take in request beats, at each rising edge.
  always @(posedge clk) begin
    rule_reply_t want;
    if (rst) begin
      reply_q.delete();
      foreach (row_vld[i]) row_vld[i] = 1'b0;
      row_count  = 0;
      pend_vld   = 1'b0;
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $error("result transaction with no prediction waiting: %h", m_tdata);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (m_tdata[2:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
            fail_count++;
          end
          if (m_tdata[3] !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, m_tdata[3]);
            fail_count++;
          end
          if (m_tdata[10:4] !== want.total) begin
            $error("rule_total: expected %0d, actual %0d", want.total, m_tdata[10:4]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_beat(s_tuser, s_tdata);
    end
    awaiting = reply_q.size();
  end

endmodule

### bench/network_rule_table_cidr_match_tb.sv
// ----------------------------------------------------------------------------
// Rule table testbench
// Drives append, remove and match requests, lone beats and unknown kinds, with
// random idling on both channels, a long result hold-off and a full drain, and
// leaves all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module network_rule_table_cidr_match_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import nrt_pkg::*;

  localparam int   ROWS         = 64;
  localparam int   IDLE_LIMIT   = 20000;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   TAIL_CYCLES  = 3 * ROWS;
  localparam logic SIDE_LOCAL   = 1'b0;
  localparam logic SIDE_REMOTE  = 1'b1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    class_t    cls;
    endpoint_t lep;
    endpoint_t rep;
  } rule_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // op_type, protocol, transport, side_present, family, port, pfx_bits,
  // addr_hi, addr_lo (from bit 0 up)
  logic [167:0] s_axis_tdata = '0;
  // kind, beat_side (from bit 0 up)
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // status, matched, rule_total (from bit 0 up)
  logic [15:0]  m_axis_tdata;

  int  fail_count;
  int  awaiting;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;
  rule_t rule_book[$];
  logic [63:0] addr_pool[4];

  always #5 clk = ~clk;

  network_rule_table_cidr_match #(.TABLE_ENTRIES(ROWS)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  network_rule_table_checker #(.ROWS(ROWS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_axis_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        m_axis_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // One request beat, held until the block takes it.
  task automatic send_beat(input logic [1:0] kind, input logic side, input class_t c,
                           input logic pres, input endpoint_t ep);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = {side, kind};
    s_axis_tdata  = {4'd0, ep.addr_lo, ep.addr_hi, ep.meta.pfx_bits, ep.meta.port,
                     ep.meta.family, pres, c.transport, c.protocol, c.op_type};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_request(input logic [1:0] kind, input class_t c, input logic lp,
                              input endpoint_t l, input logic rp, input endpoint_t r);
    send_beat(kind, SIDE_LOCAL, c, lp, l);
    send_beat(kind, SIDE_REMOTE, c, rp, r);
    if (kind == KIND_APPEND) begin
      rule_book.push_back('{c, l, r});
      if (rule_book.size() > 96) void'(rule_book.pop_front());
    end
  endtask

  function automatic class_t valid_class();
    class_t c;
    c.op_type  = 3'($urandom_range(0, 6));
    c.protocol = 3'($urandom_range(0, 4));
    case (c.protocol)
      PROTO_INET, PROTO_INET6: c.transport = 3'($urandom_range(0, 3));
      PROTO_UNIX:              c.transport = 3'($urandom_range(4, 6));
      default:                 c.transport = TRANS_RAW;
    endcase
    return c;
  endfunction

  function automatic class_t any_class();
    class_t c;
    if ($urandom_range(0, 3) != 0) return valid_class();
    c = 9'($urandom_range(0, 511));
    return c;
  endfunction

  // Endpoint mostly drawn from a small address pool so that rules meet requests.
  function automatic endpoint_t pick_endpoint(input bit clean);
    endpoint_t e;
    int        r;
    e.meta.family = clean ? 2'($urandom_range(0, 1)) :
                    ($urandom_range(0, 9) == 0 ? 2'($urandom_range(2, 3)) :
                                                 2'($urandom_range(0, 1)));
    r = $urandom_range(0, 3);
    e.meta.port = r == 0 ? 16'd0 : r == 1 ? 16'd443 : r == 2 ? 16'hFFFF : 16'($urandom);
    r = $urandom_range(0, 8);
    case (r)
      0, 1: e.meta.pfx_bits = 8'd0;
      2: e.meta.pfx_bits = 8'd24;
      3: e.meta.pfx_bits = 8'd32;
      4: e.meta.pfx_bits = 8'd64;
      5: e.meta.pfx_bits = 8'd128;
      6: e.meta.pfx_bits = 8'($urandom_range(1, 127));
      default: e.meta.pfx_bits = clean ? 8'($urandom_range(0, 128)) :
                                         8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      e.addr_hi = {$urandom, $urandom};
      e.addr_lo = {$urandom, $urandom};
    end else begin
      e.addr_hi = addr_pool[$urandom_range(0, 3)] ^ (64'($urandom_range(0, 3)) << 8);
      e.addr_lo = addr_pool[$urandom_range(0, 3)] ^ 64'($urandom_range(0, 3));
    end
    return e;
  endfunction

  // A request endpoint near a stored one: same or slightly disturbed.
  function automatic endpoint_t near(input endpoint_t e);
    endpoint_t q;
    q = e;
    case ($urandom_range(0, 5))
      0: q.meta.port = 16'($urandom);
      1: q.addr_lo = q.addr_lo ^ (64'd1 << $urandom_range(0, 63));
      2: q.addr_hi = q.addr_hi ^ (64'd1 << $urandom_range(0, 63));
      3: q.meta.family = q.meta.family ^ 2'd1;
      default: ;
    endcase
    return q;
  endfunction

  // Stimulus and verdict.
  initial begin
    class_t    c;
    endpoint_t a;
    endpoint_t b;
    endpoint_t z;
    rule_t     rb;
    int        mode;

    addr_pool[0] = 64'hC0A8_0100_0000_0000;
    addr_pool[1] = 64'h2001_0DB8_0000_0000;
    addr_pool[2] = 64'h0A00_0000_0000_0001;
    addr_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed requests.
    c = '{OP_CREATE, PROTO_INET, TRANS_TCP};
    a = '{'{FAM_IPV4, 16'd80, 8'd24}, 64'hC0A8_0105_0000_0000, 64'd0};
    b = '{'{FAM_IPV4, 16'd0, 8'd0}, 64'h0A00_0001_0000_0000, 64'd0};
    z = '{'{FAM_IPV4, 16'd0, 8'd0}, 64'd0, 64'd0};
    send_request(KIND_APPEND, c, 1'b1, a, 1'b1, b);
    send_request(KIND_MATCH, c, 1'b1, a, 1'b1, b);
    send_request(KIND_MATCH, c, 1'b1, '{'{FAM_IPV4, 16'd81, 8'd0}, a.addr_hi, 64'd0},
                 1'b1, b);
    send_request(KIND_MATCH, c, 1'b0, z, 1'b0, z);
    send_request(KIND_APPEND, '{OP_INVALID, PROTO_INET, TRANS_TCP}, 1'b1, a, 1'b1, b);
    send_request(KIND_APPEND, '{OP_CREATE, PROTO_PACKET + 3'd1, TRANS_TCP}, 1'b1, a,
                 1'b1, b);
    send_request(KIND_APPEND, '{OP_CREATE, PROTO_UNIX, TRANS_TCP}, 1'b1, a, 1'b1, b);
    send_request(KIND_APPEND, '{OP_CREATE, PROTO_NETLINK, TRANS_DGRAM + 3'd1}, 1'b1, a,
                 1'b1, b);
    send_request(KIND_APPEND, c, 1'b1, '{'{FAM_NONE, 16'd0, 8'd0}, 64'd0, 64'd0}, 1'b1, b);
    send_request(KIND_APPEND, c, 1'b1, a, 1'b1, '{'{FAM_IPV6, 16'd0, 8'd129}, 64'd0, 64'd0});
    send_request(KIND_APPEND, '{OP_RECEIVE, PROTO_INET6, TRANS_RAW}, 1'b0,
                 '{'{FAM_IPV6, 16'hFFFF, PREFIX_MAX}, '1, '1}, 1'b0,
                 '{'{FAM_IPV6, 16'd0, 8'd0}, '1, '1});
    send_request(KIND_MATCH, '{OP_RECEIVE, PROTO_INET6, TRANS_RAW}, 1'b1,
                 '{'{FAM_IPV6, 16'hFFFF, 8'hFF}, '1, '1}, 1'b1,
                 '{'{FAM_IPV6, 16'd7, 8'd0}, '1, '1});
    send_request(KIND_REMOVE, c, 1'b0, a, 1'b0, b);
    send_request(KIND_REMOVE, c, 1'b0, a, 1'b0, b);
    send_beat(KIND_MATCH, SIDE_REMOTE, c, 1'b1, b);
    send_beat(KIND_APPEND, SIDE_LOCAL, c, 1'b1, b);
    send_request(KIND_MATCH, c, 1'b1, a, 1'b1, b);
    send_request(KIND_UNKNOWN, c, 1'b1, a, 1'b1, b);

    // Fill the table past its size.
    for (int k = 0; k < ROWS + 3; k++) begin
      send_request(KIND_APPEND, valid_class(), 1'b1, pick_endpoint(1'b1), 1'b1,
                   pick_endpoint(1'b1));
    end

    // Random requests, mostly well formed.
    for (int k = 0; k < 640; k++) begin
      if (k == 200) hold_req = 1'b1;
      if (k == 300) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait (awaiting == 0);
      end
      if (k == 540) calm = 1'b1;
      mode = $urandom_range(0, 99);
      if (mode < 35) begin
        send_request(KIND_APPEND, any_class(), 1'($urandom_range(0, 1)),
                     pick_endpoint(1'b0), 1'($urandom_range(0, 1)), pick_endpoint(1'b0));
      end else if (mode < 60) begin
        if (rule_book.size() > 0 && $urandom_range(0, 4) != 0) begin
          rb = rule_book[$urandom_range(0, rule_book.size() - 1)];
        end else begin
          rb = '{any_class(), pick_endpoint(1'b0), pick_endpoint(1'b0)};
        end
        send_request(KIND_REMOVE, rb.cls, 1'($urandom_range(0, 1)), rb.lep,
                     1'($urandom_range(0, 1)), rb.rep);
      end else if (mode < 90) begin
        if (rule_book.size() > 0 && $urandom_range(0, 3) != 0) begin
          rb = rule_book[$urandom_range(0, rule_book.size() - 1)];
          rb.lep = near(rb.lep);
          rb.rep = near(rb.rep);
        end else begin
          rb = '{any_class(), pick_endpoint(1'b0), pick_endpoint(1'b0)};
        end
        send_request(KIND_MATCH, rb.cls, $urandom_range(0, 3) != 0, rb.lep,
                     $urandom_range(0, 3) != 0, rb.rep);
      end else begin
        // Noise: lone beats, unknown kinds and fully random fields.
        c = 9'($urandom_range(0, 511));
        send_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), c,
                  1'($urandom_range(0, 1)),
                  '{'{2'($urandom), 16'($urandom), 8'($urandom)},
                    {$urandom, $urandom}, {$urandom, $urandom}});
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (awaiting == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/nrt_pkg.sv
sv/nrt_cell.sv
sv/network_rule_table_cidr_match.sv
bench/network_rule_table_checker.sv
bench/network_rule_table_cidr_match_tb.sv
